### hdl/cosine_sum_window_generator_assert.svh
// assertion macros used by the window generator top level
`ifndef COSINE_SUM_WINDOW_GENERATOR_ASSERT_SVH
`define COSINE_SUM_WINDOW_GENERATOR_ASSERT_SVH

// same-cycle implication
`define CSWG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CSWG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/cswg_pkg.sv
// types, constants and arithmetic helpers of the cosine-sum window generator
package cswg_pkg;

    localparam int LEN_W      = 13;
    localparam int IDX_W      = 12;
    localparam int COEF_W     = 18;
    localparam int W_W        = 18;
    localparam int NUM_COEF   = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int PH_W       = 32;
    localparam int QUO_W      = 33;
    localparam int COS_W      = 32;
    localparam int DIV_LAT    = QUO_W;
    localparam int COS_LAT    = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMMETRIC = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF0     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF1     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF2     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF3     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF4     = 3'd6;

    localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;
    localparam logic [30:0] ONE_Q30    = 31'h4000_0000;

    // floor(x / (2^pre * b)) as ((x >> pre) * mul) >> post
    typedef struct packed {
        logic [1:0]  pre;
        logic [29:0] mul;
        logic [5:0]  post;
    } t_div_coef;

    // index {sin, step}: cos 56 30 12 2, sin 72 42 20 6
    localparam t_div_coef DIV_TAB [8] = '{
        '{2'd3, 30'd613566757, 6'd32},
        '{2'd1, 30'd572662307, 6'd33},
        '{2'd2, 30'd715827883, 6'd31},
        '{2'd1, 30'd1,         6'd0},
        '{2'd3, 30'd954437177, 6'd33},
        '{2'd1, 30'd818089009, 6'd34},
        '{2'd2, 30'd858993460, 6'd32},
        '{2'd1, 30'd715827883, 6'd31}
    };

    typedef struct packed {
        logic [IDX_W-1:0] n;
        logic             err;
    } t_q_item;

    typedef struct packed {
        logic valid;
        logic err;
    } t_tag;

    typedef struct packed {
        logic [29:0] y;
        logic [29:0] y2;
        logic [1:0]  quad;
        logic        neg;
    } t_cos_side;

    function automatic logic [29:0] mulq(input logic [30:0] a, input logic [30:0] b);
        logic [61:0] prod;
        prod = 62'(a) * 62'(b) + 62'(32'h2000_0000);
        return 30'(prod >> 30);
    endfunction

    function automatic logic [29:0] cdiv(input logic [29:0] x, input logic [2:0] sel);
        t_div_coef   c;
        logic [29:0] xs;
        logic [59:0] prod;
        c    = DIV_TAB[sel];
        xs   = x >> c.pre;
        prod = 60'(xs) * 60'(c.mul);
        return 30'(prod >> c.post);
    endfunction

endpackage

### hdl/cswg_if.sv
// item channels of the window generator
interface cswg_smp_if import cswg_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] sample_index;

    modport source (output valid, output sample_index, input ready);
    modport sink (input valid, input sample_index, output ready);
endinterface

interface cswg_win_if import cswg_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic signed [W_W-1:0] weight;
    logic                  index_error;
    logic                  saturated;

    modport source (output valid, output weight, output index_error, output saturated,
                    input ready);
    modport sink (input valid, input weight, input index_error, input saturated,
                  output ready);
endinterface

### hdl/cosine_sum_window_generator.sv
// top level of the cosine-sum window generator
// Returns one window point w(n) = sum (-1)^k a_k cos(k theta) per accepted sample index, one
// item per clock when the output side is ready. The phase n/d (d = M-1 when symmetric, else M)
// comes from a 33-stage quotient pipeline (one bit a stage), each term then runs through
// its own 10-stage cosine pipeline, and the products are summed, rounded and clipped in
// three more stages. A stalled output freezes the pipeline as a whole, while a 4-entry
// queue keeps taking indices until it is full.
// Configuration must be written only with no items in flight.
`include "cosine_sum_window_generator_assert.svh"

module cosine_sum_window_generator import cswg_pkg::*; #(
    parameter int MAX_LENGTH = 4096,
    parameter int NUM_TERMS  = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    cswg_smp_if.sink              i_smp,
    cswg_win_if.source            o_win,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int NT      = NUM_TERMS < NUM_COEF ? NUM_TERMS : NUM_COEF;
    localparam int PROD_W  = COEF_W + COS_W;
    localparam int ACC_W   = PROD_W + $clog2(NT);
    localparam int SUM_W   = ACC_W - 30;
    localparam int TAG_LEN = COS_LAT + 2;

    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(2**(W_W-1) - 1);
    localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(-(2**(W_W-1)));
    localparam logic [W_W-1:0]          OUT_MAX = W_W'(2**(W_W-1) - 1);
    localparam logic [W_W-1:0]          OUT_MIN = W_W'(2**(W_W-1));

    logic [LEN_W-1:0]         r_len;
    logic                     r_sym;
    logic signed [COEF_W-1:0] r_coef [NUM_COEF];

    logic [LEN_W-1:0] len_c;
    logic [LEN_W-1:0] d;
    logic             dz;

    logic    push;
    logic    full;
    logic    empty;
    logic    pop;
    logic    adv;
    t_q_item f_item;
    t_q_item q_item;

    t_tag                    ph_tag;
    logic [PH_W-1:0]         ph [NT];
    logic signed [COS_W-1:0] cosv [NT];

    t_tag                     r_tag  [TAG_LEN];
    logic signed [PROD_W-1:0] r_prod [NT];
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  sum;
    logic signed [ACC_W-1:0]  rnd;
    logic signed [SUM_W-1:0]  wv;

    logic                  r_out_valid;
    logic signed [W_W-1:0] r_w;
    logic                  r_ie;
    logic                  r_sat;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= LEN_W'(64);
            r_sym     <= 1'b1;
            r_coef[0] <= 18'sd32768;
            r_coef[1] <= 18'sd32768;
            r_coef[2] <= '0;
            r_coef[3] <= '0;
            r_coef[4] <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LENGTH: begin
                    r_len <= i_cfg_data[LEN_W-1:0];
                end
                CFG_SYMMETRIC: begin
                    r_sym <= i_cfg_data[0];
                end
                CFG_COEF0: begin
                    r_coef[0] <= i_cfg_data;
                end
                CFG_COEF1: begin
                    r_coef[1] <= i_cfg_data;
                end
                CFG_COEF2: begin
                    r_coef[2] <= i_cfg_data;
                end
                CFG_COEF3: begin
                    r_coef[3] <= i_cfg_data;
                end
                CFG_COEF4: begin
                    r_coef[4] <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign len_c = (int'(r_len) > MAX_LENGTH) ? LEN_W'(MAX_LENGTH) : r_len;
    assign d     = r_sym ? len_c - 1'b1 : len_c;
    assign dz    = d == '0;

    assign adv = !r_out_valid || o_win.ready;
    assign pop = adv && !empty;

    cswg_front u_front (
        .i_smp  (i_smp),
        .i_len  (len_c),
        .i_full (full),
        .o_push (push),
        .o_item (f_item)
    );

    cswg_queue #(
        .DEPTH (4)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_empty (empty)
    );

    cswg_phase #(
        .NT (NT)
    ) u_phase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (!empty),
        .i_item  (q_item),
        .i_d     (d),
        .i_dz    (dz),
        .o_tag   (ph_tag),
        .o_phase (ph)
    );

    for (genvar k = 0; k < NT; k++) begin : g_term
        cswg_cos u_cos (
            .i_clk   (i_clk),
            .i_en    (adv),
            .i_phase (ph[k]),
            .o_cos   (cosv[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TAG_LEN; i++) begin
                r_tag[i] <= '0;
            end
        end else if (adv) begin
            r_tag[0] <= ph_tag;
            for (int i = 1; i < TAG_LEN; i++) begin
                r_tag[i] <= r_tag[i-1];
            end
        end
    end

    always_comb begin
        sum = '0;
        for (int k = 0; k < NT; k++) begin
            sum = sum + ACC_W'(r_prod[k]);
        end
    end

    assign rnd = r_acc + ACC_W'(2**29);
    assign wv  = SUM_W'(rnd >>> 30);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < NT; k++) begin
                r_prod[k] <= PROD_W'(r_coef[k]) * PROD_W'(cosv[k]);
            end
            r_acc <= sum;
            r_ie  <= r_tag[TAG_LEN-1].err;
            if (r_tag[TAG_LEN-1].err) begin
                r_w   <= '0;
                r_sat <= 1'b0;
            end else if (wv > SUM_MAX) begin
                r_w   <= OUT_MAX;
                r_sat <= 1'b1;
            end else if (wv < SUM_MIN) begin
                r_w   <= OUT_MIN;
                r_sat <= 1'b1;
            end else begin
                r_w   <= W_W'(wv);
                r_sat <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_tag[TAG_LEN-1].valid;
        end
    end

    assign o_win.valid       = r_out_valid;
    assign o_win.weight      = r_w;
    assign o_win.index_error = r_ie;
    assign o_win.saturated   = r_sat;

    `CSWG_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, r_out_valid && r_ie, r_w == '0 && !r_sat, "index error item carries weight")
    `CSWG_ASSERT_NOW(a_sat_rail, i_clk, i_rst_n, r_out_valid && r_sat, r_w == OUT_MAX || r_w == OUT_MIN, "saturated weight off the rail")
    `CSWG_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, !adv, $stable(r_w) && $stable(r_out_valid), "pipeline moved while stalled")

endmodule

### hdl/cswg_queue.sv
// small item queue between the front and the compute pipeline
module cswg_queue import cswg_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_q_item i_item,
    output logic    o_full,
    input  logic    i_pop,
    output t_q_item o_item,
    output logic    o_empty
);

    localparam int AW = $clog2(DEPTH);

    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_cnt;
    t_q_item       r_mem [DEPTH];

    assign o_full  = r_cnt == (AW+1)'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= AW'(r_wr + 1'b1);
            end
            if (i_pop) begin
                r_rd <= AW'(r_rd + 1'b1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

### hdl/cswg_front.sv
// input side: takes sample indices and flags those outside the window
module cswg_front import cswg_pkg::*; (
    cswg_smp_if.sink         i_smp,
    input  logic [LEN_W-1:0] i_len,
    input  logic             i_full,
    output logic             o_push,
    output t_q_item          o_item
);

    assign i_smp.ready = !i_full;
    assign o_push      = i_smp.valid && !i_full;
    assign o_item.n    = i_smp.sample_index;
    assign o_item.err  = {1'b0, i_smp.sample_index} >= i_len;

endmodule

### hdl/cswg_phase.sv
// phase pipeline: n * 2^32 / d one quotient bit a stage, then term phases
module cswg_phase import cswg_pkg::*; #(
    parameter int NT = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_q_item          i_item,
    input  logic [LEN_W-1:0] i_d,
    input  logic             i_dz,
    output t_tag             o_tag,
    output logic [PH_W-1:0]  o_phase [NT]
);

    logic [QUO_W-1:0] r_quo  [DIV_LAT];
    logic [LEN_W-1:0] r_rem  [DIV_LAT];
    t_tag             r_dtag [DIV_LAT];
    logic [QUO_W-1:0] n_quo  [DIV_LAT];
    logic [LEN_W-1:0] n_rem  [DIV_LAT];
    t_tag             r_ptag;
    logic [PH_W-1:0]  r_phase [NT];
    logic [PH_W-1:0]  n_phase [NT];

    always_comb begin
        logic [LEN_W-1:0] n13;
        logic [LEN_W:0]   rem2;
        logic             b;
        n13      = {1'b0, i_item.n};
        b        = n13 >= i_d;
        n_rem[0] = b ? LEN_W'(n13 - i_d) : n13;
        n_quo[0] = {{(QUO_W-1){1'b0}}, b};
        for (int i = 1; i < DIV_LAT; i++) begin
            rem2     = {r_rem[i-1], 1'b0};
            b        = rem2 >= {1'b0, i_d};
            n_rem[i] = b ? LEN_W'(rem2 - {1'b0, i_d}) : LEN_W'(rem2);
            n_quo[i] = {r_quo[i-1][QUO_W-2:0], b};
        end
    end

    always_comb begin
        logic [17:0]      lhs;
        logic [2:0]       j;
        logic [PH_W-1:0]  kq;
        logic [QUO_W-1:0] quo;
        logic [LEN_W-1:0] rem;
        quo = r_quo[DIV_LAT-1];
        rem = r_rem[DIV_LAT-1];
        for (int k = 0; k < NT; k++) begin
            lhs = 18'(2 * k) * 18'(rem) + 18'(i_d);
            j   = '0;
            for (int m = 1; m < NT; m++) begin
                if (m <= k && lhs >= 18'(2 * m) * 18'(i_d)) begin
                    j = j + 1'b1;
                end
            end
            kq = PH_W'(quo * QUO_W'(k));
            if (i_dz) begin
                kq = '0;
                j  = '0;
            end
            n_phase[k] = kq + {k[0], 31'b0} + PH_W'(j);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < DIV_LAT; i++) begin
                r_quo[i] <= n_quo[i];
                r_rem[i] <= n_rem[i];
            end
            for (int k = 0; k < NT; k++) begin
                r_phase[k] <= n_phase[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_LAT; i++) begin
                r_dtag[i] <= '0;
            end
            r_ptag <= '0;
        end else if (i_en) begin
            r_dtag[0] <= '{valid: i_valid, err: i_item.err};
            for (int i = 1; i < DIV_LAT; i++) begin
                r_dtag[i] <= r_dtag[i-1];
            end
            r_ptag <= r_dtag[DIV_LAT-1];
        end
    end

    assign o_tag = r_ptag;

    always_comb begin
        for (int k = 0; k < NT; k++) begin
            o_phase[k] = r_phase[k];
        end
    end

endmodule

### hdl/cswg_cos.sv
// cosine of a 32-bit turn value in q30, folded Taylor forms over ten stages
module cswg_cos import cswg_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [PH_W-1:0]         i_phase,
    output logic signed [COS_W-1:0] o_cos
);

    t_cos_side               r_sd [1:9];
    logic [30:0]             r_t  [0:3];
    logic [29:0]             r_m  [1:3];
    logic signed [COS_W-1:0] r_cos;

    logic [PH_W-1:0] shifted;
    logic            neg;
    logic [29:0]     a;
    logic [62:0]     ya;
    logic [30:0]     v;
    logic            flip;

    assign shifted = i_phase + 32'h2000_0000;
    assign neg     = !shifted[29];
    assign a       = neg ? 30'h2000_0000 - 30'(shifted[28:0]) : 30'(shifted[28:0]);
    assign ya      = 63'(a) * 63'(TWO_PI_Q30) + 63'(32'h8000_0000);

    assign v    = r_sd[9].quad[0] ? {1'b0, mulq(31'(r_sd[9].y), r_t[3])} : r_t[3];
    assign flip = (r_sd[9].quad == 2'd2) || (r_sd[9].quad == 2'd1 && !r_sd[9].neg)
               || (r_sd[9].quad == 2'd3 && r_sd[9].neg);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd[1].y    <= ya[61:32];
            r_sd[1].y2   <= '0;
            r_sd[1].quad <= shifted[31:30];
            r_sd[1].neg  <= neg;
            r_sd[2].y    <= r_sd[1].y;
            r_sd[2].y2   <= mulq(31'(r_sd[1].y), 31'(r_sd[1].y));
            r_sd[2].quad <= r_sd[1].quad;
            r_sd[2].neg  <= r_sd[1].neg;
            for (int i = 3; i < 10; i++) begin
                r_sd[i] <= r_sd[i-1];
            end
            r_t[0] <= ONE_Q30 - 31'(cdiv(r_sd[2].y2, {r_sd[2].quad[0], 2'd0}));
            for (int s = 1; s < 4; s++) begin
                r_m[s] <= mulq(31'(r_sd[2*s+1].y2), r_t[s-1]);
                r_t[s] <= ONE_Q30 - 31'(cdiv(r_m[s], {r_sd[2*s+2].quad[0], 2'(s)}));
            end
            r_cos <= flip ? -COS_W'(v) : COS_W'(v);
        end
    end

    assign o_cos = r_cos;

endmodule
